### rtl/hqs_pkg.sv
// hqs_pkg: shared types and constants for the quickselect point-store engine.
// Holds the request/response payload structs, store entry layout and op codes.
// No dependencies.
package hqs_pkg;

   // Store geometry
   localparam int MAX_POINTS = 1024;
   localparam int AW         = $clog2(MAX_POINTS);   // entry address width
   localparam int HW         = AW + 1;               // exclusive range end width
   localparam int IW         = AW + 2;               // signed scan index width

   // Op codes
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_SELECT = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // Status codes
   localparam logic ST_OK  = 1'b0;
   localparam logic ST_BAD = 1'b1;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic [15:0]        point_tag;
      logic               axis;
      logic [AW-1:0]      range_low;
      logic [HW-1:0]      range_high;
      logic [AW-1:0]      position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic [15:0]        out_tag;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [15:0]        tag;
   } entry_type;

endpackage

### rtl/hoare_quickselect_engine.sv
// A load is written at its transfer and gives no result; a read or a bad select passes from
// S_RD_OUT or S_ERR_OUT to the result register, waiting while it is held. A valid select reads
// the pivot at mid each round, scans i and j with one read per entry, swaps by reading both
// entries and writing them back crossed, and fetches the target once the window closes, all
// through the single store read port. Throughput: loads one per cycle while idle; one read or
// select at a time. Reset: synchronous, clears the sequencer and result valid, not the store.
// hoare_quickselect_engine: point store with in-place Hoare quickselect sequencer.
// Depends on hqs_pkg.
module hoare_quickselect_engine
   import hqs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [13:0] {
      S_IDLE    = 14'b00000000000001,
      S_OUTER   = 14'b00000000000010,
      S_PIVOT   = 14'b00000000000100,
      S_LOOP    = 14'b00000000001000,
      S_SI_REQ  = 14'b00000000010000,
      S_SI_CHK  = 14'b00000000100000,
      S_SJ_REQ  = 14'b00000001000000,
      S_SJ_CHK  = 14'b00000010000000,
      S_SW_RI   = 14'b00000100000000,
      S_SW_RJ   = 14'b00001000000000,
      S_SW_WI   = 14'b00010000000000,
      S_SW_WJ   = 14'b00100000000000,
      S_RD_OUT  = 14'b01000000000000,
      S_ERR_OUT = 14'b10000000000000
   } state_type;

   function automatic logic signed [31:0] key_of(input entry_type e, input logic ax);
      return ax ? e.y : e.x;
   endfunction

   // Sequencer and window registers
   state_type             state_ff, state_in;
   logic signed [IW-1:0]  l_ff, l_in;
   logic signed [IW-1:0]  r_ff, r_in;
   logic signed [IW-1:0]  i_ff, i_in;
   logic signed [IW-1:0]  j_ff, j_in;
   logic signed [IW-1:0]  tgt_ff, tgt_in;
   logic                  axis_ff, axis_in;
   logic signed [31:0]    pivot_ff, pivot_in;
   entry_type             ent_i_ff, ent_i_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Store port
   entry_type             mem [MAX_POINTS];
   entry_type             mem_rdata_ff;
   logic                  mem_we;
   logic                  mem_re;
   logic [AW-1:0]         mem_waddr;
   logic [AW-1:0]         mem_raddr;
   entry_type             mem_wdata;

   logic                  req_xfer;
   logic                  out_free;
   logic                  bad_range;
   logic signed [IW-1:0]  mid;
   logic signed [31:0]    rd_key;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign mid    = (l_ff + r_ff) >>> 1;
   assign rd_key = key_of(mem_rdata_ff, axis_ff);

   // Select range check: need low <= position < high <= MAX_POINTS
   assign bad_range = (req_data.range_low > req_data.position) ||
                      (HW'(req_data.position) >= req_data.range_high) ||
                      (req_data.range_high > HW'(MAX_POINTS));

   // Store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end

   // Sequencer next state; accesses are serialized, so no read meets a write
   always_comb begin
      state_in     = state_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      tgt_in       = tgt_ff;
      axis_in      = axis_ff;
      pivot_in     = pivot_ff;
      ent_i_in     = ent_i_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = '0;
      mem_raddr    = '0;
      mem_wdata    = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (req_data.op)
                  OP_LOAD: begin
                     mem_we    = 1'b1;
                     mem_waddr = req_data.position;
                     mem_wdata = '{x: req_data.coord_x, y: req_data.coord_y,
                                   tag: req_data.point_tag};
                  end
                  OP_READ: begin
                     // every 10-bit position lies inside the store
                     mem_re    = 1'b1;
                     mem_raddr = req_data.position;
                     state_in  = S_RD_OUT;
                  end
                  OP_SELECT: begin
                     if (bad_range) begin
                        state_in = S_ERR_OUT;
                     end else begin
                        l_in     = IW'(req_data.range_low);
                        r_in     = IW'(req_data.range_high) - IW'(1);
                        tgt_in   = IW'(req_data.position);
                        axis_in  = req_data.axis;
                        state_in = S_OUTER;
                     end
                  end
                  default: begin
                     // unused op: drop
                  end
               endcase
            end
         end

         // Start a partition round, or fetch the target once the window closes
         S_OUTER: begin
            mem_re = 1'b1;
            if (l_ff < r_ff) begin
               mem_raddr = mid[AW-1:0];
               state_in  = S_PIVOT;
            end else begin
               mem_raddr = tgt_ff[AW-1:0];
               state_in  = S_RD_OUT;
            end
         end

         S_PIVOT: begin
            pivot_in = rd_key;
            i_in     = l_ff;
            j_in     = r_ff;
            state_in = S_LOOP;
         end

         // Partition loop test; narrow the window when the pass ends
         S_LOOP: begin
            if (i_ff <= j_ff) begin
               state_in = S_SI_REQ;
            end else begin
               if (j_ff < tgt_ff) begin
                  l_in = i_ff;
               end
               if (tgt_ff < i_ff) begin
                  r_in = j_ff;
               end
               state_in = S_OUTER;
            end
         end

         // Advance i over keys below the pivot
         S_SI_REQ: begin
            if (i_ff < r_ff) begin
               mem_re    = 1'b1;
               mem_raddr = i_ff[AW-1:0];
               state_in  = S_SI_CHK;
            end else begin
               state_in  = S_SJ_REQ;
            end
         end

         S_SI_CHK: begin
            if (rd_key < pivot_ff) begin
               i_in     = i_ff + IW'(1);
               state_in = S_SI_REQ;
            end else begin
               state_in = S_SJ_REQ;
            end
         end

         // Retreat j over keys above the pivot
         S_SJ_REQ: begin
            if (j_ff > l_ff) begin
               mem_re    = 1'b1;
               mem_raddr = j_ff[AW-1:0];
               state_in  = S_SJ_CHK;
            end else begin
               state_in  = (i_ff <= j_ff) ? S_SW_RI : S_LOOP;
            end
         end

         S_SJ_CHK: begin
            if (rd_key > pivot_ff) begin
               j_in     = j_ff - IW'(1);
               state_in = S_SJ_REQ;
            end else begin
               state_in = (i_ff <= j_ff) ? S_SW_RI : S_LOOP;
            end
         end

         // Swap entries i and j: read both, then write back crossed
         S_SW_RI: begin
            mem_re    = 1'b1;
            mem_raddr = i_ff[AW-1:0];
            state_in  = S_SW_RJ;
         end

         S_SW_RJ: begin
            ent_i_in  = mem_rdata_ff;
            mem_re    = 1'b1;
            mem_raddr = j_ff[AW-1:0];
            state_in  = S_SW_WI;
         end

         S_SW_WI: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff[AW-1:0];
            mem_wdata = mem_rdata_ff;
            state_in  = S_SW_WJ;
         end

         S_SW_WJ: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff[AW-1:0];
            mem_wdata = ent_i_ff;
            i_in      = i_ff + IW'(1);
            j_in      = j_ff - IW'(1);
            state_in  = S_LOOP;
         end

         // Hand the fetched entry to the result register
         S_RD_OUT: begin
            if (out_free) begin
               rsp_in       = '{out_x: mem_rdata_ff.x, out_y: mem_rdata_ff.y,
                                out_tag: mem_rdata_ff.tag, status: ST_OK};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_ERR_OUT: begin
            if (out_free) begin
               rsp_in       = '{out_x: '0, out_y: '0, out_tag: '0, status: ST_BAD};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      l_ff     <= l_in;
      r_ff     <= r_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      tgt_ff   <= tgt_in;
      axis_ff  <= axis_in;
      pivot_ff <= pivot_in;
      ent_i_ff <= ent_i_in;
      rsp_ff   <= rsp_in;
   end

   // A write and a read never hit the same entry in one cycle
   assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("store read and write collide");

   // Swaps only happen with i not past j
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SW_WJ) |-> (i_ff <= j_ff))
      else $error("swap with crossed indexes");

   // The j scan stays inside the window
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SJ_CHK) |-> ((j_ff > l_ff) && (j_ff <= r_ff)))
      else $error("j scan left the window");

   // A new result comes only from a finishing state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (($past(state_ff) == S_RD_OUT) ||
                               ($past(state_ff) == S_ERR_OUT)))
      else $error("result without finishing state");

   // Error results carry a zero payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == ST_BAD)) |->
         ((rsp_ff.out_tag == '0) && (rsp_ff.out_x == '0) && (rsp_ff.out_y == '0)))
      else $error("error result with nonzero payload");

endmodule
